### rtl/dll_pkg.sv
package dll_pkg;

   localparam int FuncWidth   = 3;
   localparam int DataWidth   = 32;
   localparam int StatusWidth = 3;
   localparam int FoundWidth  = 6;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_INS_HEAD = 3'd0,
      FUNC_INS_TAIL = 3'd1,
      FUNC_INS_POS  = 3'd2,
      FUNC_SEARCH   = 3'd3,
      FUNC_DEL_HEAD = 3'd4,
      FUNC_DEL_TAIL = 3'd5,
      FUNC_DEL_POS  = 3'd6,
      FUNC_NOP      = 3'd7
   } func_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // datapath micro-operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,        // latch request, set cursor to head (tail for a tail delete)
      OP_READ_CUR,    // issue memory read at cursor
      OP_STEP,        // cursor <= next of read node, bump index
      OP_TAKE,        // allocate slot for insert
      OP_LINK_HEAD,
      OP_LINK_TAIL,
      OP_LINK_MID,    // uses read node (at) as successor
      OP_UNLINK,      // unlink read node
      OP_FOUND,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
   } dll_cmd_type;

   typedef struct packed {
      logic     cur_null;
      logic     idx_done;   // walk index reached target position
      logic     match;      // read node value equals key
      logic     pool_full;
      logic     pos_gt_size;
      logic     pos_ge_size;
      logic     pos_zero;
      logic     pos_eq_size;
      logic     head_null;
      logic     tail_null;
      logic     walk_limit;
      func_type func;
   } dll_stat_type;

endpackage

### rtl/dll_datapath.sv
module dll_datapath #(
   parameter int NODES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dll_pkg::dll_cmd_type         cmd,
   output dll_pkg::dll_stat_type        stat,
   input  logic [dll_pkg::FuncWidth-1:0] req_func,
   input  logic signed [dll_pkg::DataWidth-1:0] req_value,
   input  logic [$clog2(NODES+1)-1:0]   req_position,
   output logic [dll_pkg::StatusWidth-1:0] rsp_status,
   output logic [dll_pkg::FoundWidth-1:0]  rsp_found_position,
   output logic signed [dll_pkg::DataWidth-1:0] rsp_removed_value,
   output logic [$clog2(NODES+1)-1:0]   rsp_count
);
   import dll_pkg::*;

   localparam int PW = $clog2(NODES+1);
   localparam int AW = $clog2(NODES);
   localparam logic [PW-1:0] NIL = PW'(NODES);

   logic [DataWidth-1:0] mem_value [NODES];
   logic [PW-1:0]        mem_next  [NODES];
   logic [PW-1:0]        mem_prev  [NODES];

   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, size_ff, size_in;
   logic [PW-1:0] free_ff, free_in, fresh_ff, fresh_in;
   func_type      func_ff;
   logic [DataWidth-1:0] key_ff;
   logic [PW-1:0] pos_ff, cur_ff, cur_in, idx_ff, idx_in, slot_ff, slot_in;
   logic [DataWidth-1:0] rd_value_ff;
   logic [PW-1:0] rd_next_ff, rd_prev_ff;
   logic [PW-1:0] fl_next_ff;

   // single write port per store
   logic          wv_en, wn_en, wp_en, wn2_en, wp2_en;
   logic [AW-1:0] wv_a, wn_a, wp_a, wn2_a, wp2_a;
   logic [PW-1:0] wn_d, wp_d, wn2_d, wp2_d;
   logic [AW-1:0] rd_a;

   assign rd_a = cur_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_READ_CUR && cur_ff != NIL) begin
         rd_value_ff <= mem_value[rd_a];
         rd_next_ff  <= mem_next[rd_a];
         rd_prev_ff  <= mem_prev[rd_a];
      end
      if (free_ff != NIL) begin
         fl_next_ff <= mem_next[free_ff[AW-1:0]];
      end
      if (wv_en) mem_value[wv_a] <= key_ff;
      if (wn_en) mem_next[wn_a] <= wn_d;
      else if (wn2_en) mem_next[wn2_a] <= wn2_d;
      if (wp_en) mem_prev[wp_a] <= wp_d;
      else if (wp2_en) mem_prev[wp2_a] <= wp2_d;
   end

   // second link write happens in the next cycle through a pending register
   logic          pn_ff, pp_ff;
   logic [AW-1:0] pn_a_ff, pp_a_ff;
   logic [PW-1:0] pn_d_ff, pp_d_ff;
   logic          pn_in, pp_in;
   logic [AW-1:0] pn_a_in, pp_a_in;
   logic [PW-1:0] pn_d_in, pp_d_in;

   always_comb begin
      head_in = head_ff; tail_in = tail_ff; size_in = size_ff;
      free_in = free_ff; fresh_in = fresh_ff;
      cur_in = cur_ff; idx_in = idx_ff; slot_in = slot_ff;
      wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
      wv_a = slot_ff[AW-1:0]; wn_a = slot_ff[AW-1:0]; wp_a = slot_ff[AW-1:0];
      wn_d = NIL; wp_d = NIL;
      wn2_en = pn_ff; wn2_a = pn_a_ff; wn2_d = pn_d_ff;
      wp2_en = pp_ff; wp2_a = pp_a_ff; wp2_d = pp_d_ff;
      pn_in = 1'b0; pp_in = 1'b0;
      pn_a_in = pn_a_ff; pp_a_in = pp_a_ff; pn_d_in = pn_d_ff; pp_d_in = pp_d_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            // tail delete starts at the tail, everything else at the head
            cur_in = (req_func == FUNC_DEL_TAIL) ? tail_ff : head_ff;
            idx_in = '0;
         end
         OP_STEP: begin
            cur_in = rd_next_ff;
            idx_in = idx_ff + 1'b1;
         end
         OP_TAKE: begin
            if (free_ff != NIL) begin
               slot_in = free_ff;
               free_in = fl_next_ff;
            end else begin
               slot_in = fresh_ff;
               fresh_in = fresh_ff + 1'b1;
            end
         end
         OP_LINK_HEAD: begin
            wv_en = 1'b1;
            wp_en = 1'b1; wp_d = NIL;
            wn_en = 1'b1; wn_d = head_ff;
            if (head_ff != NIL) begin
               pp_in = 1'b1; pp_a_in = head_ff[AW-1:0]; pp_d_in = slot_ff;
            end else begin
               tail_in = slot_ff;
            end
            head_in = slot_ff;
            size_in = size_ff + 1'b1;
         end
         OP_LINK_TAIL: begin
            wv_en = 1'b1;
            wn_en = 1'b1; wn_d = NIL;
            wp_en = 1'b1; wp_d = tail_ff;
            if (tail_ff != NIL) begin
               pn_in = 1'b1; pn_a_in = tail_ff[AW-1:0]; pn_d_in = slot_ff;
            end else begin
               head_in = slot_ff;
            end
            tail_in = slot_ff;
            size_in = size_ff + 1'b1;
         end
         OP_LINK_MID: begin
            wv_en = 1'b1;
            wn_en = 1'b1; wn_d = cur_ff;
            wp_en = 1'b1; wp_d = rd_prev_ff;
            if (rd_prev_ff != NIL) begin
               pn_in = 1'b1; pn_a_in = rd_prev_ff[AW-1:0]; pn_d_in = slot_ff;
            end else begin
               head_in = slot_ff;
            end
            pp_in = 1'b1; pp_a_in = cur_ff[AW-1:0]; pp_d_in = slot_ff;
            size_in = size_ff + 1'b1;
         end
         OP_UNLINK: begin
            if (rd_prev_ff != NIL) begin
               wn_en = 1'b1; wn_a = rd_prev_ff[AW-1:0]; wn_d = rd_next_ff;
            end else begin
               head_in = rd_next_ff;
            end
            if (rd_next_ff != NIL) begin
               wp_en = 1'b1; wp_a = rd_next_ff[AW-1:0]; wp_d = rd_prev_ff;
            end else begin
               tail_in = rd_prev_ff;
            end
            // freed slot links to old free head next cycle
            pn_in = 1'b1; pn_a_in = cur_ff[AW-1:0]; pn_d_in = free_ff;
            free_in = cur_ff;
            size_in = size_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL; tail_ff <= NIL; free_ff <= NIL;
         size_ff <= '0; fresh_ff <= '0;
         pn_ff <= 1'b0; pp_ff <= 1'b0;
      end else begin
         head_ff <= head_in; tail_ff <= tail_in; free_ff <= free_in;
         size_ff <= size_in; fresh_ff <= fresh_in;
         pn_ff <= pn_in; pp_ff <= pp_in;
      end
      pn_a_ff <= pn_a_in; pn_d_ff <= pn_d_in;
      pp_a_ff <= pp_a_in; pp_d_ff <= pp_d_in;
      cur_ff <= cur_in; idx_ff <= idx_in; slot_ff <= slot_in;
      if (cmd.op == OP_LOAD) begin
         func_ff <= func_type'(req_func);
         key_ff  <= req_value;
         pos_ff  <= req_position;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_status        <= cmd.status;
         rsp_found_position <= '0;
         rsp_removed_value <= '0;
         rsp_count         <= size_ff;
      end else if (cmd.op == OP_FOUND) begin
         rsp_status        <= ST_OK;
         rsp_found_position <= FoundWidth'(idx_ff);
         rsp_removed_value <= '0;
         rsp_count         <= size_ff;
      end else if (cmd.op == OP_UNLINK) begin
         rsp_status        <= ST_OK;
         rsp_found_position <= '0;
         rsp_removed_value <= rd_value_ff;
         rsp_count         <= size_in;
      end else if (cmd.op == OP_LINK_HEAD || cmd.op == OP_LINK_TAIL ||
                   cmd.op == OP_LINK_MID) begin
         rsp_status        <= ST_OK;
         rsp_found_position <= '0;
         rsp_removed_value <= '0;
         rsp_count         <= size_in;
      end
   end

   assign stat.cur_null    = (cur_ff == NIL);
   assign stat.idx_done    = (idx_ff == pos_ff);
   assign stat.match       = (rd_value_ff == key_ff);
   assign stat.pool_full   = (free_ff == NIL) && (fresh_ff == NIL);
   assign stat.pos_gt_size = (pos_ff > size_ff);
   assign stat.pos_ge_size = (pos_ff >= size_ff);
   assign stat.pos_zero    = (pos_ff == '0);
   assign stat.pos_eq_size = (pos_ff == size_ff);
   assign stat.head_null   = (head_ff == NIL);
   assign stat.tail_null   = (tail_ff == NIL);
   assign stat.walk_limit  = (idx_ff == NIL);
   assign stat.func        = func_ff;

endmodule

### rtl/dll_ctrl.sv
module dll_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dll_pkg::dll_stat_type stat,
   output dll_pkg::dll_cmd_type  cmd
);
   import dll_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECIDE = 9'b000000010,
      S_READ   = 9'b000000100,
      S_EVAL   = 9'b000001000,
      S_TAKE   = 9'b000010000,
      S_LINK   = 9'b000100000,
      S_SETTLE = 9'b001000000,
      S_RESP   = 9'b010000000,
      S_HEADRD = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_ready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd.op = OP_NONE;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.op = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            unique case (stat.func)
               FUNC_INS_HEAD, FUNC_INS_TAIL: begin
                  if (stat.pool_full) begin
                     cmd.op = OP_RESULT; cmd.status = ST_FULL;
                  end else begin
                     cmd.op = OP_TAKE; state_in = S_LINK;
                  end
               end
               FUNC_INS_POS: begin
                  if (stat.pos_gt_size) begin
                     cmd.op = OP_RESULT; cmd.status = ST_BADPOS;
                  end else if (stat.pool_full) begin
                     cmd.op = OP_RESULT; cmd.status = ST_FULL;
                  end else begin
                     cmd.op = OP_TAKE;
                     state_in = (stat.pos_zero || stat.pos_eq_size) ? S_LINK : S_EVAL;
                  end
               end
               FUNC_SEARCH: begin
                  if (stat.head_null) begin
                     cmd.op = OP_RESULT; cmd.status = ST_EMPTY;
                  end else begin
                     cmd.op = OP_READ_CUR; state_in = S_EVAL;
                  end
               end
               FUNC_DEL_HEAD, FUNC_DEL_TAIL: begin
                  if ((stat.func == FUNC_DEL_HEAD) ? stat.head_null : stat.tail_null) begin
                     cmd.op = OP_RESULT; cmd.status = ST_EMPTY;
                  end else begin
                     state_in = S_HEADRD;
                  end
               end
               FUNC_DEL_POS: begin
                  if (stat.pos_ge_size) begin
                     cmd.op = OP_RESULT; cmd.status = ST_BADPOS;
                  end else begin
                     state_in = S_EVAL;
                  end
               end
               default: begin
                  cmd.op = OP_RESULT;
               end
            endcase
         end
         S_HEADRD: begin
            // deletes at the ends: cursor already sits on the head or the tail
            cmd.op = OP_READ_CUR;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
            if (stat.func == FUNC_DEL_HEAD || stat.func == FUNC_DEL_TAIL) begin
               cmd.op = OP_UNLINK; state_in = S_SETTLE;
            end
         end
         S_EVAL: begin
            // walk: cursor holds node at index idx
            if (stat.func == FUNC_SEARCH) begin
               if (stat.match) begin
                  cmd.op = OP_FOUND; state_in = S_SETTLE;
               end else begin
                  cmd.op = OP_STEP; state_in = S_READ;
               end
            end else if (stat.idx_done) begin
               cmd.op = OP_READ_CUR; state_in = S_LINK;
            end else begin
               cmd.op = OP_READ_CUR; state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            // advance after the read
            cmd.op = OP_STEP; state_in = S_EVAL;
         end
         S_LINK: begin
            state_in = S_SETTLE;
            unique case (stat.func)
               FUNC_INS_HEAD: cmd.op = OP_LINK_HEAD;
               FUNC_INS_TAIL: cmd.op = OP_LINK_TAIL;
               FUNC_INS_POS: begin
                  if (stat.pos_zero) cmd.op = OP_LINK_HEAD;
                  else if (stat.pos_eq_size) cmd.op = OP_LINK_TAIL;
                  else cmd.op = OP_LINK_MID;
               end
               default: cmd.op = OP_UNLINK;
            endcase
         end
         S_SETTLE: begin
            // pending second link write retires here
            state_in = S_IDLE;
            valid_in = 1'b1;
         end
         S_RESP: begin
            state_in = S_IDLE;
            valid_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_READ && stat.func == FUNC_SEARCH) begin
         // after a step the new cursor may be null: no match
         if (stat.cur_null || stat.walk_limit) begin
            cmd.op = OP_RESULT; cmd.status = ST_NOTFOUND; state_in = S_RESP;
         end else begin
            cmd.op = OP_READ_CUR; state_in = S_EVAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/doubly_linked_list_engine_unit.sv
// channel   ports                                           direction
// request   req_valid req_ready req_func req_value req_position   in
// response  rsp_valid rsp_ready rsp_status rsp_found_position
//           rsp_removed_value rsp_count                            out
// One request at a time. The time from acceptance to rsp_valid grows with the
// walk: a positional insert or delete walks the list up to the position, and a
// search walks it node by node until a match or the end of the list.
// Reset clears head, tail, free chain and size; node memory is not cleared.
// A response waits in its output register until taken; the next request is
// accepted once it leaves.
module doubly_linked_list_engine_unit #(
   parameter int NODES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [dll_pkg::FuncWidth-1:0] req_func,
   input  logic signed [dll_pkg::DataWidth-1:0] req_value,
   input  logic [$clog2(NODES+1)-1:0] req_position,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [dll_pkg::StatusWidth-1:0] rsp_status,
   output logic [dll_pkg::FoundWidth-1:0] rsp_found_position,
   output logic signed [dll_pkg::DataWidth-1:0] rsp_removed_value,
   output logic [$clog2(NODES+1)-1:0] rsp_count
);
   import dll_pkg::*;

   dll_cmd_type  cmd;
   dll_stat_type stat;

   dll_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   dll_datapath #(.NODES(NODES)) u_dp (
      .clock, .reset, .cmd, .stat, .req_func, .req_value, .req_position,
      .rsp_status, .rsp_found_position, .rsp_removed_value, .rsp_count
   );

endmodule

### rtl/dll_checker.sv
module dll_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [dll_pkg::StatusWidth-1:0] rsp_status
);
   import dll_pkg::*;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule

bind doubly_linked_list_engine_unit dll_checker u_dll_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_status
);

### dv/tb_doubly_linked_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine_unit;
   import dll_pkg::*;

   localparam int NODES = 64;
   localparam int NullLink = NODES;
   localparam int CycleLimit = 2000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [FuncWidth-1:0] req_func;
   logic signed [DataWidth-1:0] req_value;
   logic [6:0] req_position;
   logic rsp_valid;
   logic rsp_ready;
   logic [StatusWidth-1:0] rsp_status;
   logic [FoundWidth-1:0] rsp_found_position;
   logic signed [DataWidth-1:0] rsp_removed_value;
   logic [6:0] rsp_count;

   doubly_linked_list_engine_unit #(.NODES(NODES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_position(rsp_found_position),
      .rsp_removed_value(rsp_removed_value),
      .rsp_count(rsp_count)
   );

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [FoundWidth-1:0] found;
      logic [DataWidth-1:0] removed;
      logic [6:0] count;
   } list_result_type;

   typedef struct {
      func_type fn;
      logic [31:0] value;
      logic [6:0] position;
      bit typed;
      list_result_type result;
   } stim_row_type;

   // shadow list state
   logic [31:0] pool_value[NODES];
   int pool_next[NODES];
   int pool_prev[NODES];
   int list_head, list_tail, list_len, free_top, fresh_slot;

   list_result_type pending_results[$];
   int mismatches;
   int cycle_count;
   int sent_count, got_count, search_hits, full_hits;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic int grab_slot();
      int n;
      if (free_top != NullLink) begin
         n = free_top;
         free_top = pool_next[n];
         return n;
      end
      if (fresh_slot < NODES) begin
         fresh_slot++;
         return fresh_slot - 1;
      end
      return NullLink;
   endfunction

   function automatic void attach_head(int n, logic [31:0] v);
      pool_value[n] = v;
      pool_prev[n] = NullLink;
      pool_next[n] = list_head;
      if (list_head != NullLink) pool_prev[list_head] = n;
      else list_tail = n;
      list_head = n;
      list_len++;
   endfunction

   function automatic void attach_tail(int n, logic [31:0] v);
      pool_value[n] = v;
      pool_next[n] = NullLink;
      pool_prev[n] = list_tail;
      if (list_tail != NullLink) pool_next[list_tail] = n;
      else list_head = n;
      list_tail = n;
      list_len++;
   endfunction

   function automatic int node_at(int p);
      int cur;
      cur = list_head;
      for (int i = 0; i < p; i++) cur = pool_next[cur];
      return cur;
   endfunction

   function automatic logic [31:0] detach(int n);
      int pv, nx;
      pv = pool_prev[n];
      nx = pool_next[n];
      if (pv != NullLink) pool_next[pv] = nx;
      else list_head = nx;
      if (nx != NullLink) pool_prev[nx] = pv;
      else list_tail = pv;
      pool_next[n] = free_top;
      free_top = n;
      list_len--;
      return pool_value[n];
   endfunction

   function automatic list_result_type apply_list_command(func_type fn, logic [31:0] v,
                                                           int p);
      list_result_type r;
      int n, at, pv, cur;
      r = '0;
      r.status = ST_OK;
      case (fn)
         FUNC_INS_HEAD, FUNC_INS_TAIL: begin
            n = grab_slot();
            if (n == NullLink) r.status = ST_FULL;
            else if (fn == FUNC_INS_HEAD) attach_head(n, v);
            else attach_tail(n, v);
         end
         FUNC_INS_POS: begin
            if (p > list_len) r.status = ST_BADPOS;
            else begin
               n = grab_slot();
               if (n == NullLink) r.status = ST_FULL;
               else if (p == 0) attach_head(n, v);
               else if (p == list_len) attach_tail(n, v);
               else begin
                  at = node_at(p);
                  pv = pool_prev[at];
                  pool_value[n] = v;
                  pool_next[n] = at;
                  pool_prev[n] = pv;
                  pool_next[pv] = n;
                  pool_prev[at] = n;
                  list_len++;
               end
            end
         end
         FUNC_SEARCH: begin
            if (list_head == NullLink) r.status = ST_EMPTY;
            else begin
               r.status = ST_NOTFOUND;
               cur = list_head;
               for (int i = 0; cur != NullLink; i++) begin
                  if (pool_value[cur] == v) begin
                     r.status = ST_OK;
                     r.found = i[FoundWidth-1:0];
                     break;
                  end
                  cur = pool_next[cur];
               end
            end
         end
         FUNC_DEL_HEAD: begin
            if (list_head == NullLink) r.status = ST_EMPTY;
            else r.removed = detach(list_head);
         end
         FUNC_DEL_TAIL: begin
            if (list_tail == NullLink) r.status = ST_EMPTY;
            else r.removed = detach(list_tail);
         end
         FUNC_DEL_POS: begin
            if (p >= list_len) r.status = ST_BADPOS;
            else r.removed = detach(node_at(p));
         end
         default: ;
      endcase
      r.count = list_len[6:0];
      return r;
   endfunction

   function automatic void clear_shadow();
      list_head = NullLink;
      list_tail = NullLink;
      free_top = NullLink;
      list_len = 0;
      fresh_slot = 0;
   endfunction

   function automatic int short_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // hold the request until it is accepted
   task automatic send_request(func_type fn, logic [31:0] v, logic [6:0] p);
      list_result_type want;
      int gap;
      gap = short_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      want = apply_list_command(fn, v, p);
      pending_results.push_back(want);
      if (fn == FUNC_SEARCH && want.status == ST_OK) search_hits++;
      if (want.status == ST_FULL) full_hits++;
      req_valid <= 1'b1;
      req_func <= fn;
      req_value <= v;
      req_position <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // response side: random backpressure, compare at the accepting edge
   initial begin
      list_result_type want, seen;
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = short_gap();
         rsp_ready <= (stall == 0);
         if (stall != 0) begin
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         seen.status = rsp_status;
         seen.found = rsp_found_position;
         seen.removed = rsp_removed_value;
         seen.count = rsp_count;
         got_count++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", seen);
         end else begin
            want = pending_results.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected status %0d found %0d removed %0h count %0d, got status %0d found %0d removed %0h count %0d",
                           got_count, want.status, want.found, want.removed, want.count,
                           seen.status, seen.found, seen.removed, seen.count);
            end
         end
         @(negedge clock);
      end
   end

   function automatic stim_row_type row(func_type fn, logic [31:0] v, logic [6:0] p,
                                        bit typed, logic [2:0] st, logic [31:0] rm,
                                        logic [6:0] cnt);
      stim_row_type s;
      s.fn = fn;
      s.value = v;
      s.position = p;
      s.typed = typed;
      s.result = '{status: st, found: '0, removed: rm, count: cnt};
      return s;
   endfunction

   initial begin
      stim_row_type directed[$];
      list_result_type peek;
      func_type fn;
      logic [31:0] v;
      int p, roll;
      mismatches = 0;
      sent_count = 0;
      got_count = 0;
      search_hits = 0;
      full_hits = 0;
      clear_shadow();
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_NOP;
      req_value = '0;
      req_position = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list cases, extremes, then every operation
      directed.push_back(row(FUNC_DEL_HEAD, 32'h0, 7'd0, 1, ST_EMPTY, 0, 0));
      directed.push_back(row(FUNC_DEL_TAIL, 32'h0, 7'd0, 1, ST_EMPTY, 0, 0));
      directed.push_back(row(FUNC_SEARCH, 32'h5, 7'd0, 1, ST_EMPTY, 0, 0));
      directed.push_back(row(FUNC_DEL_POS, 32'h0, 7'd0, 1, ST_BADPOS, 0, 0));
      directed.push_back(row(FUNC_INS_POS, 32'h1, 7'd1, 1, ST_BADPOS, 0, 0));
      directed.push_back(row(FUNC_NOP, 32'hFFFFFFFF, 7'd127, 1, ST_OK, 0, 0));
      directed.push_back(row(FUNC_INS_HEAD, 32'h80000000, 7'd0, 1, ST_OK, 0, 1));
      directed.push_back(row(FUNC_INS_TAIL, 32'h7FFFFFFF, 7'd0, 1, ST_OK, 0, 2));
      directed.push_back(row(FUNC_INS_POS, 32'hFFFFFFFF, 7'd1, 1, ST_OK, 0, 3));
      directed.push_back(row(FUNC_INS_POS, 32'h0, 7'd3, 0, 0, 0, 0));
      directed.push_back(row(FUNC_INS_POS, 32'h1, 7'd0, 0, 0, 0, 0));
      directed.push_back(row(FUNC_INS_POS, 32'h2, 7'd64, 1, ST_BADPOS, 0, 5));
      directed.push_back(row(FUNC_SEARCH, 32'h7FFFFFFF, 7'd0, 0, 0, 0, 0));
      directed.push_back(row(FUNC_SEARCH, 32'h12345678, 7'd0, 0, 0, 0, 0));
      directed.push_back(row(FUNC_DEL_POS, 32'h0, 7'd2, 0, 0, 0, 0));
      directed.push_back(row(FUNC_DEL_POS, 32'h0, 7'd127, 1, ST_BADPOS, 0, 4));
      directed.push_back(row(FUNC_DEL_HEAD, 32'h0, 7'd0, 1, ST_OK, 32'h1, 3));
      directed.push_back(row(FUNC_DEL_TAIL, 32'h0, 7'd0, 0, 0, 0, 0));
      directed.push_back(row(FUNC_NOP, 32'h0, 7'd0, 0, 0, 0, 0));

      foreach (directed[i]) begin
         if (directed[i].typed) begin
            // compare typed-in value against the shadow copy
            peek = apply_list_command(directed[i].fn, directed[i].value,
                                      directed[i].position);
            clear_shadow();
            for (int k = 0; k < i; k++)
               void'(apply_list_command(directed[k].fn, directed[k].value,
                                        directed[k].position));
            if (peek !== directed[i].result) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("directed row %0d: predicted %p, table %p", i, peek,
                           directed[i].result);
            end
         end
         send_request(directed[i].fn, directed[i].value, directed[i].position);
      end

      // random phase: alternate growth and drain so the pool fills and recycles
      for (int k = 0; k < 1650; k++) begin
         roll = $urandom_range(0, 99);
         if ((k / 200) % 2 == 0) begin
            if (roll < 55) fn = func_type'($urandom_range(0, 2));
            else if (roll < 80) fn = FUNC_SEARCH;
            else fn = func_type'($urandom_range(4, 7));
         end else begin
            if (roll < 25) fn = func_type'($urandom_range(0, 2));
            else if (roll < 45) fn = FUNC_SEARCH;
            else fn = func_type'($urandom_range(4, 7));
         end
         // small value alphabet so searches hit often
         if ($urandom_range(0, 3) == 0) v = $urandom;
         else v = $urandom_range(0, 15);
         if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 127);
         else p = $urandom_range(0, list_len);
         send_request(fn, v, p[6:0]);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * NODES + 10) @(posedge clock);
      $display("%0d requests, %0d responses, %0d search hits, %0d pool-full rejects",
               sent_count, got_count, search_hits, full_hits);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### doubly_linked_list_engine_unit.f
rtl/dll_pkg.sv
rtl/dll_datapath.sv
rtl/dll_ctrl.sv
rtl/doubly_linked_list_engine_unit.sv
rtl/dll_checker.sv
dv/tb_doubly_linked_list_engine_unit.sv
